### hdl/ccoq_pkg.sv
package ccoq_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int FLOOR_W    = 4;
    localparam int POS_W      = 12;
    localparam int FRAC_BITS  = 8;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = $clog2(LIST_DEPTH);

    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    typedef logic [1:0]         kind_t;
    typedef logic [1:0]         status_t;
    typedef logic [FLOOR_W-1:0] floor_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [CNT_W-1:0]   count_t;

    localparam kind_t KIND_POSITION = 2'd0;
    localparam kind_t KIND_CALL     = 2'd1;
    localparam kind_t KIND_STOP     = 2'd2;
    localparam kind_t KIND_SERVED   = 2'd3;

    localparam status_t ST_ACCEPTED  = 2'd0;
    localparam status_t ST_DUPLICATE = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NO_CALL   = 2'd3;

endpackage

### hdl/cabin_call_ordered_queue.sv
// Sequence: position, stop and served items, and a call into an empty list, go from
// acceptance through SEQ_FIN to the registered result; any other call first compares
// list entries in SEQ_WALK (up to LIST_DEPTH), then passes SEQ_INSERT and SEQ_FIN,
// skipping SEQ_INSERT when it ends on a duplicate. Flow: one item at a time; s_tready
// returns once the result has been taken, and the walk uses the single entry comparator.
// Reset (aresetn low, synchronous): list empty, position 0, stopped flag clear, no result.
module cabin_call_ordered_queue
    import ccoq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // call_floor[3:0], new_position[15:4]
    input  logic [1:0]           s_tuser,  // kind[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // status[1:0], entry_count[6:2], head_floor[10:7],
                                           // head_valid[11], is_stopped[12], zero[15:13]
);

    localparam logic [1:0] SEQ_IDLE   = 2'd0;
    localparam logic [1:0] SEQ_WALK   = 2'd1;
    localparam logic [1:0] SEQ_INSERT = 2'd2;
    localparam logic [1:0] SEQ_FIN    = 2'd3;

    logic [1:0] state_reg, state_next;
    floor_t     floor_reg, floor_next;
    logic       rising_reg, rising_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    count_t     slot_reg, slot_next;
    status_t    status_reg, status_next;
    floor_t     list_reg [LIST_DEPTH];
    floor_t     list_next [LIST_DEPTH];
    count_t     len_reg, len_next;
    pos_t       pos_reg, pos_next;
    logic       stopped_reg, stopped_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    kind_t  in_kind;
    floor_t in_floor;
    pos_t   in_pos;
    floor_t entry;
    logic   past_point;
    logic   s_accept;

    assign in_kind  = s_tuser;
    assign in_floor = s_tdata[FLOOR_W-1:0];
    assign in_pos   = s_tdata[FLOOR_W +: POS_W];

    assign s_tready = (state_reg == SEQ_IDLE) && !m_tvalid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign entry      = list_reg[idx_reg];
    assign past_point = rising_reg ? (entry > floor_reg) : (entry < floor_reg);

    always_comb begin
        state_next    = state_reg;
        floor_next    = floor_reg;
        rising_next   = rising_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        status_next   = status_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        stopped_next  = stopped_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            list_next[i] = list_reg[i];
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            SEQ_IDLE: begin
                if (s_accept) begin
                    floor_next  = in_floor;
                    rising_next = pos_reg < {in_floor, {FRAC_BITS{1'b0}}};
                    idx_next    = '0;
                    status_next = ST_NO_CALL;
                    state_next  = SEQ_FIN;
                    case (in_kind)
                        KIND_POSITION: begin
                            pos_next = in_pos;
                        end
                        KIND_CALL: begin
                            stopped_next = 1'b0;
                            if (len_reg == '0) begin
                                list_next[0] = in_floor;
                                len_next     = count_t'(1);
                                status_next  = ST_ACCEPTED;
                            end else begin
                                state_next = SEQ_WALK;
                            end
                        end
                        KIND_STOP: begin
                            len_next     = '0;
                            stopped_next = 1'b1;
                        end
                        default: begin
                            // served: drop the head
                            if (len_reg != '0) begin
                                for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                                    list_next[i] = list_reg[i+1];
                                end
                                len_next = len_reg - count_t'(1);
                            end
                        end
                    endcase
                end
            end
            SEQ_WALK: begin
                if (past_point) begin
                    slot_next  = count_t'(idx_reg);
                    state_next = SEQ_INSERT;
                end else if (entry == floor_reg) begin
                    status_next = ST_DUPLICATE;
                    state_next  = SEQ_FIN;
                end else if (count_t'(idx_reg) == len_reg - count_t'(1)) begin
                    slot_next  = len_reg;
                    state_next = SEQ_INSERT;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            SEQ_INSERT: begin
                state_next = SEQ_FIN;
                if (len_reg >= count_t'(LIST_DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    // open a gap at the slot and shift the tail up
                    for (int i = 0; i < LIST_DEPTH; i++) begin
                        if (count_t'(i) == slot_reg) begin
                            list_next[i] = floor_reg;
                        end
                    end
                    for (int i = 1; i < LIST_DEPTH; i++) begin
                        if (count_t'(i) > slot_reg) begin
                            list_next[i] = list_reg[i-1];
                        end
                    end
                    len_next    = len_reg + count_t'(1);
                    status_next = ST_ACCEPTED;
                end
            end
            default: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = '0;
                m_tdata_next[1:0]  = status_reg;
                m_tdata_next[6:2]  = len_reg;
                m_tdata_next[10:7] = (len_reg != '0) ? list_reg[0] : '0;
                m_tdata_next[11]   = (len_reg != '0);
                m_tdata_next[12]   = stopped_reg;
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SEQ_IDLE;
            len_reg      <= '0;
            pos_reg      <= '0;
            stopped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            stopped_reg  <= stopped_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        floor_reg   <= floor_next;
        rising_reg  <= rising_next;
        idx_reg     <= idx_next;
        slot_reg    <= slot_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            list_reg[i] <= list_next[i];
        end
    end

endmodule

### hdl/ccoq_checker.sv
module ccoq_checker
    import ccoq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // head_valid tracks a nonzero entry count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11] == (m_tdata[6:2] != '0)))
        else $error("head_valid disagrees with entry_count");

    // count never exceeds the list depth, empty head reads as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:2] <= CNT_W'(LIST_DEPTH))
                     && (m_tdata[11] || m_tdata[10:7] == '0))
        else $error("bad count or head on empty list");

    // one item at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind cabin_call_ordered_queue ccoq_checker u_ccoq_checker (.*);
